// ----- design/cnfq_pkg.sv -----
// Shared types, codes and defaults for the CNF query over bit matrix block.
`timescale 1ns / 1ps

package cnfq_pkg;

  localparam int NUM_CELLS_DEF = 64;
  localparam int NUM_GENES_DEF = 256;
  localparam int MAX_QUERY_ENTRIES_DEF = 32;

  localparam int GENE_W = 8;
  localparam int ROW_W  = 64;
  localparam int CELL_W = 6;
  localparam int CFG_W  = 7;
  localparam int OP_W   = 3;

  localparam logic [CFG_W-1:0] CELLS_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_LOAD_ROW   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_LIT    = 3'd1;
  localparam logic [OP_W-1:0] OP_END_CLAUSE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
  localparam logic [OP_W-1:0] OP_RUN        = 3'd4;

  typedef struct packed {
    logic              is_end;
    logic              pol;
    logic [GENE_W-1:0] gene;
  } qentry_t;

  typedef struct packed {
    logic load_row;
    logic add_lit;
    logic end_clause;
    logic clear_q;
    logic start_run;
    logic walk;
    logic load_hits;
    logic scan_step;
    logic emit_none;
  } cnfq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic pipe_empty;
    logic hits_none;
    logic rem_zero;
    logic cur_hit;
    logic out_free;
  } cnfq_sts_t;

endpackage

// ----- design/cnfq_ctrl.sv -----
// Controller state machine: decodes operations and sequences a query run.
`timescale 1ns / 1ps

module cnfq_ctrl import cnfq_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] operation,
  input  cnfq_sts_t       sts,
  output cnfq_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_LOAD_ROW:   cmd.load_row   = 1'b1;
            OP_ADD_LIT:    cmd.add_lit    = 1'b1;
            OP_END_CLAUSE: cmd.end_clause = 1'b1;
            OP_CLEAR:      cmd.clear_q    = 1'b1;
            OP_RUN: begin
              cmd.start_run = 1'b1;
              state_next    = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.load_hits = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hits_none) begin
          if (sts.out_free) begin
            cmd.emit_none = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (sts.rem_zero) begin
          state_next = ST_IDLE;
        end else if (!sts.cur_hit || sts.out_free) begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/cnfq_datapath.sv -----
// Datapath: gene row memory, query table, clause evaluation pipeline and hit scan.
`timescale 1ns / 1ps

module cnfq_datapath import cnfq_pkg::*; #(
  parameter int NUM_CELLS         = NUM_CELLS_DEF,
  parameter int NUM_GENES         = NUM_GENES_DEF,
  parameter int MAX_QUERY_ENTRIES = MAX_QUERY_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cnfq_cmd_t         cmd,
  output cnfq_sts_t         sts,
  input  logic [GENE_W-1:0] gene,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic              polarity,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CELL_W-1:0] cell_res,
  output logic              found,
  output logic              last,
  output logic              status
);

  localparam int GW = $clog2(NUM_GENES);
  localparam int QW = $clog2(MAX_QUERY_ENTRIES);
  localparam int CW = $clog2(MAX_QUERY_ENTRIES + 1);

  logic [NUM_CELLS-1:0] gene_rows [NUM_GENES];
  qentry_t              query_entries [MAX_QUERY_ENTRIES];

  logic [CW-1:0]        query_count;
  logic                 query_overflow;
  logic [CFG_W-1:0]     cells_in_use;
  logic [CW-1:0]        run_idx;

  logic                 q_rd_v;
  qentry_t              q_data;
  logic                 row_v;
  logic [NUM_CELLS-1:0] row_q;
  logic                 s2_pol;
  logic                 s2_end;
  logic                 s2_oob;

  logic [NUM_CELLS-1:0] acc;
  logic [NUM_CELLS-1:0] clause;
  logic [NUM_CELLS-1:0] rem;
  logic [NUM_CELLS-1:0] mask;
  logic [NUM_CELLS-1:0] hits;
  logic [NUM_CELLS-1:0] row_eff;
  logic [NUM_CELLS-1:0] lit;
  logic [CELL_W-1:0]    scan_idx;
  logic                 hits_none;

  logic                 push;
  logic                 table_full;
  logic                 load_ok;
  qentry_t              new_entry;

  assign push       = cmd.add_lit || cmd.end_clause;
  assign table_full = (query_count == CW'(MAX_QUERY_ENTRIES));
  assign load_ok    = (32'(gene) < NUM_GENES);

  always_comb begin
    new_entry.is_end = cmd.end_clause;
    new_entry.pol    = cmd.end_clause ? 1'b0 : polarity;
    new_entry.gene   = cmd.end_clause ? '0 : gene;
  end

  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      mask[i] = (32'(cells_in_use) > i);
    end
  end

  assign hits    = acc & mask;
  assign row_eff = s2_oob ? '0 : row_q;
  assign lit     = s2_pol ? row_eff : ~row_eff;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_row && load_ok) begin
      gene_rows[GW'(gene)] <= row_bits[NUM_CELLS-1:0];
    end
    row_q <= gene_rows[GW'(q_data.gene)];
  end

  always_ff @(posedge clk) begin
    if (push && !table_full) begin
      query_entries[query_count[QW-1:0]] <= new_entry;
    end
    q_data <= query_entries[run_idx[QW-1:0]];
  end

  // payload registers of the evaluation pipeline
  always_ff @(posedge clk) begin
    s2_pol <= q_data.pol;
    s2_end <= q_data.is_end;
    s2_oob <= !(32'(q_data.gene) < NUM_GENES);
    if (cmd.start_run) begin
      acc    <= '1;
      clause <= '0;
    end else if (row_v) begin
      if (s2_end) begin
        acc    <= acc & clause;
        clause <= '0;
      end else begin
        clause <= clause | lit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_count    <= '0;
      query_overflow <= 1'b0;
      cells_in_use   <= CELLS_RESET;
      run_idx        <= '0;
      q_rd_v         <= 1'b0;
      row_v          <= 1'b0;
      rem            <= '0;
      hits_none      <= 1'b0;
      scan_idx       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        cells_in_use <= cfg_data;
      end
      if (cmd.clear_q) begin
        query_count    <= '0;
        query_overflow <= 1'b0;
      end else if (push) begin
        if (table_full) begin
          query_overflow <= 1'b1;
        end else begin
          query_count <= query_count + 1'b1;
        end
      end

      if (cmd.start_run) begin
        run_idx <= '0;
      end else if (cmd.walk) begin
        run_idx <= run_idx + 1'b1;
      end
      q_rd_v <= cmd.walk;
      row_v  <= q_rd_v;

      if ((cmd.scan_step && rem[0]) || cmd.emit_none) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.load_hits) begin
        rem       <= hits;
        hits_none <= (hits == '0);
        scan_idx  <= '0;
      end else if (cmd.scan_step) begin
        rem      <= rem >> 1;
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.scan_step && rem[0]) begin
      cell_res <= scan_idx;
      found    <= 1'b1;
      last     <= ((rem >> 1) == '0);
      status   <= query_overflow;
    end else if (cmd.emit_none) begin
      cell_res <= '0;
      found    <= 1'b0;
      last     <= 1'b1;
      status   <= query_overflow;
    end
  end

  always_comb begin
    sts.walk_done  = (run_idx == query_count);
    sts.pipe_empty = !q_rd_v && !row_v;
    sts.hits_none  = hits_none;
    sts.rem_zero   = (rem == '0);
    sts.cur_hit    = rem[0];
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// ----- design/cnf_query_over_bit_matrix.sv -----
// CNF query over a bit matrix: top level joining controller and datapath.
// Row load, literal, clause end, clear and unknown codes leave the controller idle: ready again next cycle.
// Run: the query table is walked, the evaluation pipeline drains and the hits are scanned cell by
// cell from cell 0 upward; no new request is taken until the scan ends.
// Each hit is sent as the scan reaches its cell; a stalled result holds the scan.
// Synchronous reset empties the query and sets cells_in_use to 64; memories stay undefined.
`timescale 1ns / 1ps

module cnf_query_over_bit_matrix import cnfq_pkg::*; #(
  parameter int NUM_CELLS         = NUM_CELLS_DEF,
  parameter int NUM_GENES         = NUM_GENES_DEF,
  parameter int MAX_QUERY_ENTRIES = MAX_QUERY_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [GENE_W-1:0] gene,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic              polarity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] cell_res,
  output logic              found,
  output logic              last,
  output logic              status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  cnfq_cmd_t cmd;
  cnfq_sts_t sts;

  assign cfg_ready = 1'b1;

  cnfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  cnfq_datapath #(
    .NUM_CELLS         (NUM_CELLS),
    .NUM_GENES         (NUM_GENES),
    .MAX_QUERY_ENTRIES (MAX_QUERY_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .gene      (gene),
    .row_bits  (row_bits),
    .polarity  (polarity),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cell_res  (cell_res),
    .found     (found),
    .last      (last),
    .status    (status)
  );

endmodule
